@@ design/rbd_pkg.sv @@
package rbd_pkg;

  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic             clear;
    logic             enable;
    op_t              op;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

@@ design/ring_buffer_deque.sv @@
// Double-ended queue of up to min(DEPTH, 31) entries of 32 bits.
//
// Input stream (s_*): one transaction per operation. s_tuser carries the
// opcode (push front, push back, pop front, pop back), s_tdata the payload
// that a push stores. A push to a full queue and a pop from an empty one
// take no effect but still return a result.
// Output stream (m_*): one transaction per input transaction, in order,
// with the accepted flag, the front and back entries, the entry count and
// the empty and full flags after the operation.
// The block takes one operation every cycle unless the receiver stalls: the
// row of cells is updated at the edge the operation is taken, and the result
// is read straight from the front and back ends of the row. A new operation
// is taken whenever the result register is empty or is drained in that cycle.
// When the receiver stalls, the result holds and s_tready drops.
// The APB register capacity_in_use (address 0) sets how many entries fit;
// 0 reads as 1, values above the row length are capped. Writing it empties
// the queue. Reset empties the queue and sets capacity to min(16, DEPTH).
module ring_buffer_deque import rbd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  // slave side
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic [OP_W-1:0]    s_tuser,   // [1:0] op
  // master side
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] accepted, [32:1] front_value, [64:33] back_value, [69:65] count,
  // [70] is_empty, [71] is_full
  output logic [71:0]        m_tdata,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NCELL = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(NCELL);
  localparam logic [CNT_W-1:0] CAP_RESET = (DEPTH < 16) ? CNT_W'(DEPTH) : CNT_W'(16);

  logic [CNT_W-1:0]   capacity;
  logic [CNT_W-1:0]   cap_wdata;
  logic               cfg_hit;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accepted;
  logic               in_fire;
  logic               takes_effect;
  op_t                op;
  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] a_q [NCELL];
  logic [VALUE_W-1:0] b_q [NCELL];

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_hit = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata  = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, capacity};

  // clamp the written capacity into 1 .. row length
  always_comb begin
    cap_wdata = pwdata[CNT_W-1:0];
    if (cap_wdata == '0) begin
      cap_wdata = CNT_W'(1);
    end else if (cap_wdata > CAP_MAX) begin
      cap_wdata = CAP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_hit) begin
      capacity <= cap_wdata;
    end
  end

  // ---------------- operation control ----------------
  assign s_tready = ~m_tvalid | m_tready;
  assign in_fire  = s_tvalid & s_tready;
  assign op       = op_t'(s_tuser);

  // pushes need room, pops need an entry
  always_comb begin
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: takes_effect = (count < capacity);
      OP_POP_FRONT,  OP_POP_BACK:  takes_effect = (count != '0);
      default:                     takes_effect = 1'b0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (in_fire && takes_effect) begin
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        count_next = count + CNT_W'(1);
      end else begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      accepted <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
      accepted <= takes_effect;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign ctrl.clear  = rst | cfg_hit;
  assign ctrl.enable = in_fire & takes_effect;
  assign ctrl.op     = op;
  assign ctrl.count  = count;

  // ---------------- row of cells ----------------
  // Cell 0 is the front in the a chain and the back in the b chain; a new entry
  // enters cell 0 of its own end's chain and the first free cell of the other; vacated cells read as zero.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [VALUE_W-1:0] a_prev;
    logic [VALUE_W-1:0] b_prev;
    logic [VALUE_W-1:0] a_succ;
    logic [VALUE_W-1:0] b_succ;

    if (i == 0) begin : g_head
      assign a_prev = s_tdata;
      assign b_prev = s_tdata;
    end else begin : g_body
      assign a_prev = a_q[i-1];
      assign b_prev = b_q[i-1];
    end

    if (i == NCELL - 1) begin : g_tail
      assign a_succ = '0;
      assign b_succ = '0;
    end else begin : g_link
      assign a_succ = a_q[i+1];
      assign b_succ = b_q[i+1];
    end

    rbd_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .value  (s_tdata),
      .a_prev (a_prev),
      .a_succ (a_succ),
      .b_prev (b_prev),
      .b_succ (b_succ),
      .a      (a_q[i]),
      .b      (b_q[i])
    );
  end

  // ---------------- result ----------------
  assign m_tdata = {capacity == count, count == '0, count, b_q[0], a_q[0], accepted};

  // ---------------- assertions ----------------
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("entry count above capacity");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (a_q[0] == '0 && b_q[0] == '0))
    else $error("empty queue shows a nonzero entry");

  a_refused_push_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !cfg_hit && count == capacity &&
     (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
      |=> ($stable(count) && !accepted))
    else $error("push into a full queue changed the count");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result is stalled");

endmodule

@@ design/rbd_cell.sv @@
// One position of the deque: a holds the entry at this distance from the
// front, b the entry at this distance from the back.
module rbd_cell import rbd_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [VALUE_W-1:0] value,
  input  logic [VALUE_W-1:0] a_prev,
  input  logic [VALUE_W-1:0] a_succ,
  input  logic [VALUE_W-1:0] b_prev,
  input  logic [VALUE_W-1:0] b_succ,
  output logic [VALUE_W-1:0] a,
  output logic [VALUE_W-1:0] b
);

  logic hit_free;
  logic hit_last;

  // first free position, and last held position
  assign hit_free = (ctrl.count == CNT_W'(INDEX));
  assign hit_last = (ctrl.count == CNT_W'(INDEX + 1));

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      a <= '0;
      b <= '0;
    end else if (ctrl.enable) begin
      unique case (ctrl.op)
        OP_PUSH_FRONT: begin
          a <= a_prev;
          if (hit_free) b <= value;
        end
        OP_PUSH_BACK: begin
          b <= b_prev;
          if (hit_free) a <= value;
        end
        OP_POP_FRONT: begin
          a <= a_succ;
          if (hit_last) b <= '0;
        end
        OP_POP_BACK: begin
          b <= b_succ;
          if (hit_last) a <= '0;
        end
        default: begin
          a <= a;
        end
      endcase
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Check the ring_buffer_deque block against a behavioral deque model:
// a directed table of corner cases, then randomized push/pop bursts across
// several capacity settings.
module tb import rbd_pkg::*;;

  localparam logic [2:0] CAP_ADDR  = 3'd0;  // capacity_in_use register
  localparam int         SLOTS     = 16;
  localparam int         PHASES    = 7;
  localparam int         PER_PHASE = 200;

  // Result transaction, packed to match m_tdata from bit 0 upward
  typedef struct packed {
    logic        is_full;
    logic        is_empty;
    logic [4:0]  count;
    logic [31:0] back_value;
    logic [31:0] front_value;
    logic        accepted;
  } deque_result_t;

  // Expectation pinned by the directed table, or left to the model
  typedef struct packed {
    logic          on;
    deque_result_t res;
  } pinned_t;

  // One row of the directed table: an operation or a capacity write
  typedef struct packed {
    logic          cfg;
    logic          pinned;
    op_t           op;
    logic [31:0]   arg;
    deque_result_t want;
  } row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // [31:0] value
  logic [1:0]  s_tuser  = '0;  // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] accepted, [32:1] front_value, [64:33] back_value, [69:65] count,
  // [70] is_empty, [71] is_full
  logic [71:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model state: circular store, wrap indices, fill level, capacity
  logic [31:0] store [SLOTS];
  int          head_idx;
  int          tail_idx;
  int          held;
  int          cap;

  deque_result_t expected_q [$];  // results still owed by the block
  pinned_t       pinned_q [$];    // table expectations of items in flight
  int            mismatches = 0;
  logic          calm = 1'b0;     // suppress idling on both sides
  row_t          plan [$];

  ring_buffer_deque i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Map a raw register value onto the range the block actually uses
  function automatic int clamp_cap(logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (int'(raw) > SLOTS) return SLOTS;
    return int'(raw);
  endfunction

  // Empty the model deque; reset and every capacity write do this
  function automatic void restart_deque(int c);
    cap      = c;
    held     = 0;
    tail_idx = 0;
    head_idx = (c == 1) ? 0 : 1;
    for (int i = 0; i < SLOTS; i++) store[i] = '0;
  endfunction

  // Apply one operation to the model and return the result it produces
  function automatic deque_result_t apply_op(op_t op, logic [31:0] v);
    int            fi;
    int            bi;
    int            pos;
    logic          ok;
    deque_result_t r;
    fi = head_idx % cap;
    bi = tail_idx % cap;
    ok = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (held < cap) begin
          pos = (fi + cap - 1) % cap;
          store[pos] = v;
          fi = pos;
          held++;
          ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (held < cap) begin
          pos = (bi + 1) % cap;
          store[pos] = v;
          bi = pos;
          held++;
          ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held != 0) begin
          store[fi] = '0;
          fi = (fi + 1) % cap;
          held--;
          ok = 1'b1;
        end
      end
      default: begin
        if (held != 0) begin
          store[bi] = '0;
          bi = (bi + cap - 1) % cap;
          held--;
          ok = 1'b1;
        end
      end
    endcase
    head_idx      = fi;
    tail_idx      = bi;
    r.accepted    = ok;
    r.front_value = store[fi];
    r.back_value  = store[bi];
    r.count       = held[4:0];
    r.is_empty    = (held == 0);
    r.is_full     = (held == cap);
    return r;
  endfunction

  function automatic row_t op_row(op_t op, logic [31:0] v);
    row_t r;
    r        = '0;
    r.op     = op;
    r.arg    = v;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [31:0] word);
    row_t r;
    r     = '0;
    r.cfg = 1'b1;
    r.arg = word;
    return r;
  endfunction

  function automatic row_t typed_row(op_t op, logic [31:0] v, logic acc,
                                     logic [31:0] fv, logic [31:0] bv,
                                     logic [4:0] cnt, logic emp, logic full);
    row_t r;
    r        = op_row(op, v);
    r.pinned = 1'b1;
    r.want   = '{is_full: full, is_empty: emp, count: cnt, back_value: bv,
                 front_value: fv, accepted: acc};
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Present one operation and hold it until the block takes it.
  // Entered and left at a falling edge; tvalid stays high on exit.
  task automatic send_op(op_t op, logic [31:0] v, pinned_t pin);
    while (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back(pin);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Write the capacity register, then read it back
  task automatic set_capacity(logic [31:0] word);
    logic [31:0] want;
    want    = 32'(clamp_cap(word[4:0]));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    restart_deque(int'(want));
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: capacity read expected %h, got %h", $time, want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: drop tready about 36 percent of the time unless calm
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 36);
  end

  // Scoreboard: predict on each input transaction, compare each output one
  always @(posedge clk) begin
    pinned_t       pin;
    deque_result_t model;
    deque_result_t want;
    deque_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pin   = pinned_q.pop_front();
        model = apply_op(op_t'(s_tuser), s_tdata);
        expected_q.push_back(pin.on ? pin.res : model);
      end
      if (m_tvalid && m_tready) begin
        got = deque_result_t'(m_tdata);
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, m_tdata);
        end else begin
          want = expected_q.pop_front();
          check_field("accepted",    32'(want.accepted),    32'(got.accepted));
          check_field("front_value", want.front_value,      got.front_value);
          check_field("back_value",  want.back_value,       got.back_value);
          check_field("count",       32'(want.count),       32'(got.count));
          check_field("is_empty",    32'(want.is_empty),    32'(got.is_empty));
          check_field("is_full",     32'(want.is_full),     32'(got.is_full));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    op_t         op;
    logic [31:0] word;
    int          pause_at;
    int          run_left;
    logic        filling;

    restart_deque(SLOTS);

    // Empty deque at the reset capacity: pops are refused, then a few
    // pushes and pops from both ends
    plan.push_back(typed_row(OP_POP_FRONT, 32'h0, 1'b0, '0, '0, 5'd0, 1'b1, 1'b0));
    plan.push_back(typed_row(OP_POP_BACK,  32'h0, 1'b0, '0, '0, 5'd0, 1'b1, 1'b0));
    plan.push_back(typed_row(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0));
    plan.push_back(typed_row(OP_PUSH_FRONT, 32'h0, 1'b1, 32'h0, 32'hFFFF_FFFF,
                             5'd2, 1'b0, 1'b0));
    plan.push_back(op_row(OP_PUSH_FRONT, 32'hA5A5_A5A5));
    plan.push_back(op_row(OP_PUSH_BACK,  32'h5A5A_5A5A));
    plan.push_back(op_row(OP_POP_FRONT,  32'hFFFF_FFFF));
    plan.push_back(op_row(OP_POP_BACK,   32'h0));
    // Capacity one: both ends share the single slot, full after one push
    plan.push_back(cfg_row(32'd1));
    plan.push_back(typed_row(OP_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'h1234_5678,
                             32'h1234_5678, 5'd1, 1'b0, 1'b1));
    plan.push_back(typed_row(OP_PUSH_BACK, 32'h9, 1'b0, 32'h1234_5678,
                             32'h1234_5678, 5'd1, 1'b0, 1'b1));
    plan.push_back(typed_row(OP_PUSH_FRONT, 32'h9, 1'b0, 32'h1234_5678,
                             32'h1234_5678, 5'd1, 1'b0, 1'b1));
    plan.push_back(typed_row(OP_POP_BACK, 32'h0, 1'b1, '0, '0, 5'd0, 1'b1, 1'b0));
    plan.push_back(typed_row(OP_PUSH_BACK, 32'h8000_0000, 1'b1, 32'h8000_0000,
                             32'h8000_0000, 5'd1, 1'b0, 1'b1));
    plan.push_back(typed_row(OP_POP_FRONT, 32'h0, 1'b1, '0, '0, 5'd0, 1'b1, 1'b0));
    // A zero capacity is taken as one
    plan.push_back(cfg_row(32'd0));
    plan.push_back(typed_row(OP_PUSH_BACK, 32'h1, 1'b1, 32'h1, 32'h1,
                             5'd1, 1'b0, 1'b1));
    // An oversized capacity is capped; the write also empties the deque
    plan.push_back(cfg_row(32'd31));
    plan.push_back(typed_row(OP_POP_FRONT, 32'h0, 1'b0, '0, '0, 5'd0, 1'b1, 1'b0));
    // Capacity three: fill, refuse, wrap around, drain to empty
    plan.push_back(cfg_row(32'd3));
    plan.push_back(op_row(OP_PUSH_BACK,  32'h11));
    plan.push_back(op_row(OP_PUSH_BACK,  32'h22));
    plan.push_back(op_row(OP_PUSH_FRONT, 32'h33));
    plan.push_back(op_row(OP_PUSH_BACK,  32'h44));
    plan.push_back(op_row(OP_POP_FRONT,  32'h0));
    plan.push_back(op_row(OP_PUSH_BACK,  32'h55));
    plan.push_back(op_row(OP_POP_BACK,   32'h0));
    plan.push_back(op_row(OP_POP_FRONT,  32'h0));
    plan.push_back(op_row(OP_POP_FRONT,  32'h0));

    // Hold reset, then release it at a falling edge
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        set_capacity(plan[i].arg);
      end else begin
        send_op(plan[i].op, plan[i].arg, '{on: plan[i].pinned, res: plan[i].want});
      end
    end

    // Random phases: alternate push-heavy and pop-heavy bursts so the deque
    // keeps hitting full and empty and the indices wrap
    filling  = 1'b1;
    run_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       word = 32'd16;
        1:       word = 32'd1;
        2:       word = 32'd2;
        3:       word = 32'd16;
        4:       word = 32'd17;
        default: word = 32'($urandom_range(0, 31));
      endcase
      // junk in the unused upper bits must not matter
      if (ph >= 4) word = ($urandom() & 32'hFFFF_FFE0) | word;
      settle();
      set_capacity(word);
      calm     = (ph == 3);
      pause_at = $urandom_range(20, PER_PHASE - 20);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n == pause_at) settle();
        if (run_left == 0) begin
          filling  = ~filling;
          run_left = $urandom_range(8, 40);
        end
        run_left--;
        if ($urandom_range(99) < 10) begin
          op = op_t'($urandom_range(0, 3));
        end else if (($urandom_range(99) < 80) == filling) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        send_op(op, pick_value(), '0);
      end
    end
    calm = 1'b0;

    // Drain, then give the output stage a little time to show strays
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
